/* hdl/radial_distance_remap_macros.svh */
// ---------------------------------------------------------------------------
// radial distance remap assertion macros
// shared concurrent property helpers for the remap block
// ---------------------------------------------------------------------------
`ifndef RADIAL_DISTANCE_REMAP_MACROS_SVH
`define RADIAL_DISTANCE_REMAP_MACROS_SVH

// same-cycle implication under reset
`define RDR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rdr assertion failed");

// next-cycle implication under reset
`define RDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rdr assertion failed");

`endif

/* hdl/rdr_pkg.sv */
// ---------------------------------------------------------------------------
// rdr_pkg
// shared types, constants and the root lookup for the radial remapper
// ---------------------------------------------------------------------------
package rdr_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int TABLE_DEPTH = 2048;
	localparam int TAB_AW      = $clog2(TABLE_DEPTH);

	// item actions
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_COORD = 2'd1;
	localparam logic [1:0] ACT_TEXEL = 2'd2;

	// register indexes
	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_BILINEAR = 2'd2;
	localparam logic [1:0] REG_BLEND    = 2'd3;

	// result kinds
	localparam logic KIND_COORD = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ROW  = 8'b0000_0010,
		ST_RAD  = 8'b0000_0100,
		ST_LOOK = 8'b0000_1000,
		ST_MUL  = 8'b0001_0000,
		ST_CORD = 8'b0010_0000,
		ST_TEX1 = 8'b0100_0000,
		ST_TEX2 = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic accept;
		logic row;
		logic rad;
		logic look;
		logic mul;
		logic coord_out;
		logic tex_mul;
		logic tex_out;
	} cmd_t;

	typedef struct packed {
		logic out_block;
	} status_t;

	localparam logic [7:0] ROOT_LUT [256] = '{
		8'd0, 8'd16, 8'd22, 8'd27, 8'd32, 8'd35, 8'd39, 8'd42, 8'd45, 8'd48, 8'd50, 8'd53,
		8'd55, 8'd57, 8'd59, 8'd61, 8'd64, 8'd65, 8'd67, 8'd69, 8'd71, 8'd73, 8'd75, 8'd76,
		8'd78, 8'd80, 8'd81, 8'd83, 8'd84, 8'd86, 8'd87, 8'd89, 8'd90, 8'd91, 8'd93, 8'd94,
		8'd96, 8'd97, 8'd98, 8'd99, 8'd101, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108,
		8'd109, 8'd110, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
		8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd128, 8'd128, 8'd129,
		8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136, 8'd137, 8'd138, 8'd139,
		8'd140, 8'd141, 8'd142, 8'd143, 8'd144, 8'd144, 8'd145, 8'd146, 8'd147, 8'd148,
		8'd149, 8'd150, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155, 8'd155, 8'd156,
		8'd157, 8'd158, 8'd159, 8'd160, 8'd160, 8'd161, 8'd162, 8'd163, 8'd163, 8'd164,
		8'd165, 8'd166, 8'd167, 8'd167, 8'd168, 8'd169, 8'd170, 8'd170, 8'd171, 8'd172,
		8'd173, 8'd173, 8'd174, 8'd175, 8'd176, 8'd176, 8'd177, 8'd178, 8'd178, 8'd179,
		8'd180, 8'd181, 8'd181, 8'd182, 8'd183, 8'd183, 8'd184, 8'd185, 8'd185, 8'd186,
		8'd187, 8'd187, 8'd188, 8'd189, 8'd189, 8'd190, 8'd191, 8'd192, 8'd192, 8'd193,
		8'd193, 8'd194, 8'd195, 8'd195, 8'd196, 8'd197, 8'd197, 8'd198, 8'd199, 8'd199,
		8'd200, 8'd201, 8'd201, 8'd202, 8'd203, 8'd203, 8'd204, 8'd204, 8'd205, 8'd206,
		8'd206, 8'd207, 8'd208, 8'd208, 8'd209, 8'd209, 8'd210, 8'd211, 8'd211, 8'd212,
		8'd212, 8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216, 8'd217, 8'd217, 8'd218,
		8'd218, 8'd219, 8'd219, 8'd220, 8'd221, 8'd221, 8'd222, 8'd222, 8'd223, 8'd224,
		8'd224, 8'd225, 8'd225, 8'd226, 8'd226, 8'd227, 8'd227, 8'd228, 8'd229, 8'd229,
		8'd230, 8'd230, 8'd231, 8'd231, 8'd232, 8'd232, 8'd233, 8'd234, 8'd234, 8'd235,
		8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238, 8'd239, 8'd240, 8'd240,
		8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244, 8'd244, 8'd245, 8'd245,
		8'd246, 8'd246, 8'd247, 8'd247, 8'd248, 8'd248, 8'd249, 8'd249, 8'd250, 8'd250,
		8'd251, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd255
	};

	// approximate square root of a 23-bit radius term, result up to 2880
	function automatic logic [11:0] approx_root(input logic [22:0] n);
		logic [3:0]  k;
		logic [22:0] sh;
		logic [7:0]  idx;
		logic [15:0] val;
		k = 4'd0;
		sh = '0;
		idx = '0;
		val = '0;
		if (n >= 23'd64) begin
			// exponent: count of octave thresholds passed
			for (int i = 0; i < 8; i++) begin
				if (n >= (23'd256 << (2 * i)))
					k = k + 4'd1;
			end
			sh = n >> {k, 1'b0};
			idx = sh[7:0];
			val = (16'(ROOT_LUT[idx]) << k) >> 4;
		end else if (n >= 23'd16) begin
			val = 16'(ROOT_LUT[{n[5:0], 2'b00}] >> 5);
		end else if (n >= 23'd4) begin
			val = 16'(ROOT_LUT[{n[3:0], 4'b0000}] >> 6);
		end else begin
			val = 16'(ROOT_LUT[{n[1:0], 6'b000000}] >> 7);
		end
		return val[11:0];
	endfunction

endpackage

/* hdl/rdr_ctrl.sv */
// ---------------------------------------------------------------------------
// rdr_ctrl
// sequencer for the remapper: steps one item at a time through the datapath
// ---------------------------------------------------------------------------
`include "radial_distance_remap_macros.svh"

module rdr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       action,
	output logic             in_stall,
	input  rdr_pkg::status_t status,
	output rdr_pkg::cmd_t    cmd
);
	import rdr_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_COORD)
					state_d = ST_ROW;
				else if (accept && action == ACT_TEXEL)
					state_d = ST_TEX1;
			end
			ST_ROW:  state_d = ST_RAD;
			ST_RAD:  state_d = ST_LOOK;
			ST_LOOK: state_d = ST_MUL;
			ST_MUL:  state_d = ST_CORD;
			ST_CORD: begin
				if (!status.out_block)
					state_d = ST_IDLE;
			end
			ST_TEX1: state_d = ST_TEX2;
			ST_TEX2: begin
				if (!status.out_block)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		cmd.accept    = accept;
		cmd.row       = (state_q == ST_ROW);
		cmd.rad       = (state_q == ST_RAD);
		cmd.look      = (state_q == ST_LOOK);
		cmd.mul       = (state_q == ST_MUL);
		cmd.coord_out = (state_q == ST_CORD) && !status.out_block;
		cmd.tex_mul   = (state_q == ST_TEX1);
		cmd.tex_out   = (state_q == ST_TEX2) && !status.out_block;
	end

	`RDR_ASSERT_NEXT(a_coord_start, clk, arst_n, accept && action == ACT_COORD, state_q == ST_ROW)
	`RDR_ASSERT_NOW(a_out_free, clk, arst_n, cmd.coord_out || cmd.tex_out, !status.out_block)
	`RDR_ASSERT_NEXT(a_mul_after_look, clk, arst_n, state_q == ST_LOOK, state_q == ST_MUL)
endmodule

/* hdl/rdr_datapath.sv */
// ---------------------------------------------------------------------------
// rdr_datapath
// registers, scale table, radius and coordinate arithmetic, texel filter
// ---------------------------------------------------------------------------
module rdr_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  rdr_pkg::cmd_t    cmd,
	output rdr_pkg::status_t status,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [11:0]      cfg_data,
	input  logic [1:0]       action,
	input  logic [10:0]      table_index,
	input  logic [15:0]      table_value,
	input  logic [31:0]      texel_00,
	input  logic [31:0]      texel_01,
	input  logic [31:0]      texel_10,
	input  logic [31:0]      texel_11,
	input  logic [31:0]      current_pixel,
	input  logic             out_stall,
	output logic             out_valid,
	output logic             kind,
	output logic [10:0]      source_x,
	output logic [10:0]      source_y,
	output logic [7:0]       frac_x,
	output logic [7:0]       frac_y,
	output logic [31:0]      out_pixel,
	output logic             row_end,
	output logic             frame_end
);
	import rdr_pkg::*;

	// configuration
	logic [11:0] width_q, height_q;
	logic        bilinear_q, blend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 12'd320;
			height_q   <= 12'd240;
			bilinear_q <= 1'b0;
			blend_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:    width_q    <= cfg_data;
				REG_HEIGHT:   height_q   <= cfg_data;
				REG_BILINEAR: bilinear_q <= cfg_data[0];
				REG_BLEND:    blend_q    <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// saturated frame size and half size
	logic [11:0] w_eff, h_eff;
	logic [10:0] w2, h2;

	always_comb begin
		w_eff = width_q;
		if (width_q < 12'd2)
			w_eff = 12'd2;
		else if (width_q > 12'(MAX_WIDTH))
			w_eff = 12'(MAX_WIDTH);
		h_eff = height_q;
		if (height_q < 12'd2)
			h_eff = 12'd2;
		else if (height_q > 12'(MAX_HEIGHT))
			h_eff = 12'(MAX_HEIGHT);
	end

	assign w2 = w_eff[11:1];
	assign h2 = h_eff[11:1];

	// scale table
	logic [15:0]       scale_mem [TABLE_DEPTH];
	logic [15:0]       scale_rd_q;
	logic [TAB_AW-1:0] root_addr;
	logic [11:0]       root;

	always_ff @(posedge clk) begin
		if (cmd.accept && action == ACT_LOAD)
			scale_mem[table_index[TAB_AW-1:0]] <= table_value;
		if (cmd.look)
			scale_rd_q <= scale_mem[root_addr];
	end

	// raster state
	logic [10:0]        row_q, col_q, row_eff;
	logic signed [11:0] ty_c, ty_q;
	logic [21:0]        sq_w_q;
	logic [20:0]        sq_t_q;
	logic [21:0]        ty_sq;
	logic signed [21:0] ty_x;
	logic [22:0]        rad_q;
	logic signed [12:0] step_q;
	logic signed [11:0] offx_q;
	logic [7:0]         hfx_q, hfy_q;

	assign row_eff = ({1'b0, row_q} >= h_eff) ? 11'd0 : row_q;
	assign ty_c = $signed({1'b0, row_eff}) - $signed({1'b0, h2});
	assign ty_x = 22'(ty_c);
	assign ty_sq = 22'(ty_x * ty_x);

	assign root = approx_root(rad_q);
	assign root_addr = (root >= 12'(TABLE_DEPTH)) ? TAB_AW'(TABLE_DEPTH - 1)
		: root[TAB_AW-1:0];

	// row terms
	always_ff @(posedge clk) begin
		if (cmd.row) begin
			ty_q   <= ty_c;
			sq_w_q <= 22'(w2) * 22'(w2);
			sq_t_q <= ty_sq[20:0];
		end
	end

	// scaled offsets
	logic signed [28:0] rd_x, offx_x, ty_w;
	logic signed [28:0] xp_s1, yp_s1;

	assign rd_x   = 29'($signed(scale_rd_q));
	assign offx_x = 29'(offx_q);
	assign ty_w   = 29'(ty_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			xp_s1 <= rd_x * offx_x + 29'sd128;
			yp_s1 <= rd_x * ty_w + 29'sd128;
		end
	end

	// source coordinate and clamp
	logic signed [21:0] sx_c, sy_c;
	logic [11:0]        hi_x, hi_y;
	logic [10:0]        sx_cl, sy_cl;
	logic [7:0]         fx_c, fy_c;

	always_comb begin
		sx_c = 22'(xp_s1 >>> 8) + $signed({11'd0, w2});
		sy_c = 22'(yp_s1 >>> 8) + $signed({11'd0, h2});
		hi_x = bilinear_q ? (w_eff - 12'd2) : (w_eff - 12'd1);
		hi_y = bilinear_q ? (h_eff - 12'd2) : (h_eff - 12'd1);
		if (sx_c < 0)
			sx_cl = 11'd0;
		else if (sx_c > $signed({10'd0, hi_x}))
			sx_cl = hi_x[10:0];
		else
			sx_cl = sx_c[10:0];
		if (sy_c < 0)
			sy_cl = 11'd0;
		else if (sy_c > $signed({10'd0, hi_y}))
			sy_cl = hi_y[10:0];
		else
			sy_cl = sy_c[10:0];
		fx_c = bilinear_q ? xp_s1[7:0] : 8'd0;
		fy_c = bilinear_q ? yp_s1[7:0] : 8'd0;
	end

	logic rend_c, fend_c;

	assign rend_c = ({1'b0, col_q} >= (w_eff - 12'd1));
	assign fend_c = rend_c && ({1'b0, row_q} >= (h_eff - 12'd1));

	// raster counters and radius recurrence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			rad_q  <= '0;
			step_q <= '0;
			offx_q <= '0;
			hfx_q  <= '0;
			hfy_q  <= '0;
		end else begin
			if (cmd.row)
				row_q <= row_eff;
			if (cmd.rad && col_q == 11'd0) begin
				rad_q  <= 23'(sq_w_q) + 23'(w2) + 23'(sq_t_q) + 23'd256;
				step_q <= -$signed({1'b0, w2, 1'b0});
				offx_q <= -$signed({1'b0, w2});
			end
			if (cmd.mul) begin
				rad_q  <= rad_q + 23'(unsigned'(23'(step_q)));
				step_q <= step_q + 13'sd2;
				offx_q <= offx_q + 12'sd1;
			end
			if (cmd.coord_out) begin
				hfx_q <= fx_c;
				hfy_q <= fy_c;
				if (rend_c) begin
					col_q <= '0;
					row_q <= fend_c ? 11'd0 : row_q + 11'd1;
				end else begin
					col_q <= col_q + 11'd1;
				end
			end
		end
	end

	// texel capture
	logic [31:0] t00_q, t01_q, t10_q, t11_q, cur_q;

	always_ff @(posedge clk) begin
		if (cmd.accept && action == ACT_TEXEL) begin
			t00_q <= texel_00;
			t01_q <= texel_01;
			t10_q <= texel_10;
			t11_q <= texel_11;
			cur_q <= current_pixel;
		end
	end

	// horizontal interpolation per channel
	logic [8:0]  ifx, ify;
	logic [7:0]  top_s1 [3];
	logic [7:0]  bot_s1 [3];
	logic [16:0] top_c [3];
	logic [16:0] bot_c [3];
	logic [16:0] fin_c [3];

	assign ifx = 9'd256 - {1'b0, hfx_q};
	assign ify = 9'd256 - {1'b0, hfy_q};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			top_c[c] = 17'(t00_q[8*c +: 8]) * 17'(ifx) + 17'(t01_q[8*c +: 8]) * 17'(hfx_q);
			bot_c[c] = 17'(t10_q[8*c +: 8]) * 17'(ifx) + 17'(t11_q[8*c +: 8]) * 17'(hfx_q);
			fin_c[c] = 17'(top_s1[c]) * 17'(ify) + 17'(bot_s1[c]) * 17'(hfy_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tex_mul) begin
			for (int c = 0; c < 3; c++) begin
				top_s1[c] <= top_c[c][15:8];
				bot_s1[c] <= bot_c[c][15:8];
			end
		end
	end

	// vertical interpolation and blend
	logic [31:0] px_c, blend_c;

	always_comb begin
		if (bilinear_q)
			px_c = {8'd0, fin_c[2][15:8], fin_c[1][15:8], fin_c[0][15:8]};
		else
			px_c = t00_q;
		blend_c = ((px_c >> 1) & 32'h7f7f7f7f) + ((cur_q >> 1) & 32'h7f7f7f7f);
	end

	// output register
	logic out_valid_q;

	assign status.out_block = out_valid_q && out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.coord_out || cmd.tex_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	logic        kind_q, rend_q, fend_q;
	logic [10:0] sx_q, sy_q;
	logic [7:0]  fx_q, fy_q;
	logic [31:0] pix_q;

	always_ff @(posedge clk) begin
		if (cmd.coord_out) begin
			kind_q <= KIND_COORD;
			sx_q   <= sx_cl;
			sy_q   <= sy_cl;
			fx_q   <= fx_c;
			fy_q   <= fy_c;
			pix_q  <= '0;
			rend_q <= rend_c;
			fend_q <= fend_c;
		end else if (cmd.tex_out) begin
			kind_q <= KIND_PIXEL;
			sx_q   <= '0;
			sy_q   <= '0;
			fx_q   <= '0;
			fy_q   <= '0;
			pix_q  <= blend_q ? blend_c : px_c;
			rend_q <= 1'b0;
			fend_q <= 1'b0;
		end
	end

	assign kind      = kind_q;
	assign source_x  = sx_q;
	assign source_y  = sy_q;
	assign frac_x    = fx_q;
	assign frac_y    = fy_q;
	assign out_pixel = pix_q;
	assign row_end   = rend_q;
	assign frame_end = fend_q;
endmodule

/* hdl/radial_distance_remap.sv */
// ---------------------------------------------------------------------------
// radial_distance_remap
// radial displacement remapper: table load, coordinate and texel items
// ---------------------------------------------------------------------------
// a coordinate item walks the row, radius, table read, multiply and output
// states to the output register, a texel item the multiply and output states;
//   one item at a time, and an output state waits while a result is stalled
// table load items are written when accepted and give no result
// reset: asynchronous, sequencer idle, counters zero, size 320 x 240
// the scale table is not cleared and reads undefined until written
module radial_distance_remap (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [10:0] table_index,
	input  logic [15:0] table_value,
	input  logic [31:0] texel_00,
	input  logic [31:0] texel_01,
	input  logic [31:0] texel_10,
	input  logic [31:0] texel_11,
	input  logic [31:0] current_pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [10:0] source_x,
	output logic [10:0] source_y,
	output logic [7:0]  frac_x,
	output logic [7:0]  frac_y,
	output logic [31:0] out_pixel,
	output logic        row_end,
	output logic        frame_end
);
	import rdr_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer
	rdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and storage
	rdr_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.table_index   (table_index),
		.table_value   (table_value),
		.texel_00      (texel_00),
		.texel_01      (texel_01),
		.texel_10      (texel_10),
		.texel_11      (texel_11),
		.current_pixel (current_pixel),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.kind          (kind),
		.source_x      (source_x),
		.source_y      (source_y),
		.frac_x        (frac_x),
		.frac_y        (frac_y),
		.out_pixel     (out_pixel),
		.row_end       (row_end),
		.frame_end     (frame_end)
	);
endmodule

/* tb/radial_distance_remap_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// radial_distance_remap_tb
// self-checking bench for the radial remapper: scale table loads, raster
// coordinate beats and texel beats go in through a queue-fed driver, a
// predictor mirrors the block state and a monitor compares every result
// beat field by field, with random idling on both sides and size changes
// ---------------------------------------------------------------------------
module radial_distance_remap_tb;
	import rdr_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		logic [1:0]  act;
		logic [10:0] tidx;
		logic [15:0] tval;
		logic [31:0] t00, t01, t10, t11, cur;
	} remap_beat_t;

	typedef struct {
		logic        kind;
		logic [10:0] sx, sy;
		logic [7:0]  fx, fy;
		logic [31:0] pix;
		logic        rend, fend;
	} remap_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = '0;
	logic [10:0] table_index = '0;
	logic [15:0] table_value = '0;
	logic [31:0] texel_00 = '0, texel_01 = '0, texel_10 = '0, texel_11 = '0;
	logic [31:0] current_pixel = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [10:0] source_x, source_y;
	logic [7:0]  frac_x, frac_y;
	logic [31:0] out_pixel;
	logic        row_end, frame_end;

	radial_distance_remap uut (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	remap_beat_t   pending_beats[$];
	remap_result_t pending_results[$];
	int            cycles = 0;
	int            errors = 0;
	logic          in_took = 1'b0;

	// predictor state
	logic signed [15:0] scale_mem [TABLE_DEPTH];
	bit                 scale_written [TABLE_DEPTH];
	int                 reg_width = 320, reg_height = 240;
	bit                 reg_bilinear = 0, reg_blend = 0;
	int                 row_ctr = 0, col_ctr = 0;
	int                 rad_sq = 0, rad_step = 0, off_x = 0;
	int                 hold_fx = 0, hold_fy = 0;

	function automatic int sat_size(int v);
		if (v < 2) return 2;
		return (v > 2048) ? 2048 : v;
	endfunction

	function automatic int clamp_to(int v, int hi);
		if (v < 0) return 0;
		return (v > hi) ? hi : v;
	endfunction

	// table-based square root, saturated to the last table entry
	function automatic int table_root(int unsigned n);
		int unsigned k, r;
		k = 0;
		if (n >= 64) begin
			while (k < 12 && 64'(n) >= (64'h100 << (2 * k)))
				k++;
			r = (int'(ROOT_LUT[(n >> (2 * k)) & 8'hff]) << k) >> 4;
		end else if (n >= 16) begin
			r = ROOT_LUT[(n << 2) & 8'hff] >> 5;
		end else if (n >= 4) begin
			r = ROOT_LUT[(n << 4) & 8'hff] >> 6;
		end else begin
			r = ROOT_LUT[(n << 6) & 8'hff] >> 7;
		end
		return (r >= TABLE_DEPTH) ? TABLE_DEPTH - 1 : r;
	endfunction

	// table entry the next coordinate beat will read
	function automatic int next_root();
		int h, h2, w2, r, ty, sq;
		h = sat_size(reg_height);
		h2 = h / 2;
		w2 = sat_size(reg_width) / 2;
		r = (row_ctr >= h) ? 0 : row_ctr;
		ty = r - h2;
		sq = (col_ctr == 0) ? w2 * w2 + w2 + ty * ty + 256 : rad_sq;
		return table_root(sq);
	endfunction

	function automatic int lerp_byte(logic [31:0] a, b, c, d, int s, int fx, int fy);
		int p0, p1, p2, p3, top, bot;
		p0 = (a >> s) & 8'hff;
		p1 = (b >> s) & 8'hff;
		p2 = (c >> s) & 8'hff;
		p3 = (d >> s) & 8'hff;
		top = (p0 * (256 - fx) + p1 * fx) >> 8;
		bot = (p2 * (256 - fx) + p3 * fx) >> 8;
		return ((top * (256 - fy) + bot * fy) >> 8) & 8'hff;
	endfunction

	// advance the mirrored state by one beat and queue what it produces
	task automatic predict_remap(remap_beat_t b);
		remap_result_t res;
		int w, h, w2, h2, ty, qd, xp, yp, sx, sy, rt;
		logic [31:0] px;
		res = '{default: '0};
		case (b.act)
			ACT_LOAD: begin
				scale_mem[b.tidx] = b.tval;
				scale_written[b.tidx] = 1;
			end
			ACT_COORD: begin
				w = sat_size(reg_width);
				h = sat_size(reg_height);
				w2 = w / 2;
				h2 = h / 2;
				if (row_ctr >= h) row_ctr = 0;
				ty = row_ctr - h2;
				// row terms reload at the first column
				if (col_ctr == 0) begin
					rad_sq = w2 * w2 + w2 + ty * ty + 256;
					rad_step = -2 * w2;
					off_x = -w2;
				end
				rt = table_root(rad_sq);
				qd = scale_mem[rt];
				rad_sq += rad_step;
				rad_step += 2;
				xp = qd * off_x + 128;
				yp = qd * ty + 128;
				sx = w2 + (xp >>> 8);
				sy = h2 + (yp >>> 8);
				off_x++;
				if (reg_bilinear) begin
					sx = clamp_to(sx, w - 2);
					sy = clamp_to(sy, h - 2);
					hold_fx = xp & 8'hff;
					hold_fy = yp & 8'hff;
				end else begin
					sx = clamp_to(sx, w - 1);
					sy = clamp_to(sy, h - 1);
					hold_fx = 0;
					hold_fy = 0;
				end
				// raster walk with wrap on overrun
				if (col_ctr >= w - 1) begin
					col_ctr = 0;
					res.rend = 1'b1;
					if (row_ctr >= h - 1) begin
						row_ctr = 0;
						res.fend = 1'b1;
					end else begin
						row_ctr++;
					end
				end else begin
					col_ctr++;
				end
				res.kind = KIND_COORD;
				res.sx = sx[10:0];
				res.sy = sy[10:0];
				res.fx = hold_fx[7:0];
				res.fy = hold_fy[7:0];
				pending_results.push_back(res);
			end
			ACT_TEXEL: begin
				if (reg_bilinear) begin
					px = '0;
					for (int s = 0; s < 24; s += 8)
						px |= 32'(lerp_byte(b.t00, b.t01, b.t10, b.t11, s, hold_fx, hold_fy)) << s;
				end else begin
					px = b.t00;
				end
				if (reg_blend)
					px = ((px >> 1) & 32'h7f7f7f7f) + ((b.cur >> 1) & 32'h7f7f7f7f);
				res.kind = KIND_PIXEL;
				res.pix = px;
				pending_results.push_back(res);
			end
			default: ;
		endcase
	endtask

	function automatic logic [15:0] rand_scale();
		int r;
		r = $urandom_range(0, 3);
		if (r < 2) return 16'($urandom_range(128, 512));
		if (r == 2) return 16'($urandom_range(0, 1024) - 512);
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] rand_texel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return $urandom;
	endfunction

	task automatic queue_beat(remap_beat_t b);
		predict_remap(b);
		pending_beats.push_back(b);
	endtask

	task automatic queue_load(int idx, logic [15:0] val);
		remap_beat_t b;
		b = '{default: '0};
		b.act = ACT_LOAD;
		b.tidx = idx[10:0];
		b.tval = val;
		queue_beat(b);
	endtask

	// coordinate beat, preceded by a load when its table entry is unwritten
	task automatic queue_coord();
		remap_beat_t b;
		int rt;
		rt = next_root();
		if (!scale_written[rt])
			queue_load(rt, rand_scale());
		b = '{default: '0};
		b.act = ACT_COORD;
		b.tidx = 11'($urandom);
		b.tval = 16'($urandom);
		queue_beat(b);
	endtask

	task automatic queue_texel(logic [31:0] fill, bit use_fill);
		remap_beat_t b;
		b.act = ACT_TEXEL;
		b.tidx = 11'($urandom);
		b.tval = 16'($urandom);
		b.t00 = use_fill ? fill : rand_texel();
		b.t01 = use_fill ? fill : rand_texel();
		b.t10 = use_fill ? fill : rand_texel();
		b.t11 = use_fill ? fill : rand_texel();
		b.cur = use_fill ? ~fill : rand_texel();
		queue_beat(b);
	endtask

	task automatic queue_unknown();
		remap_beat_t b;
		b.act = 2'd3;
		b.tidx = 11'($urandom);
		b.tval = 16'($urandom);
		b.t00 = $urandom;
		b.t01 = $urandom;
		b.t10 = $urandom;
		b.t11 = $urandom;
		b.cur = $urandom;
		queue_beat(b);
	endtask

	// block idle: nothing queued, nothing in flight
	task automatic wait_idle();
		while (pending_beats.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[11:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH:    reg_width = val & 12'hfff;
			REG_HEIGHT:   reg_height = val & 12'hfff;
			REG_BILINEAR: reg_bilinear = val[0];
			REG_BLEND:    reg_blend = val[0];
			default: ;
		endcase
	endtask

	function automatic int pick_size(int r);
		case (r)
			0: return $urandom_range(0, 1);
			1: return 2048;
			2: return $urandom_range(2049, 4095);
			3, 4, 5: return $urandom_range(2, 40);
			default: return $urandom_range(2, 8);
		endcase
	endfunction

	// stimulus
	initial begin
		int n;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: table extremes, every action, nearest mode at reset size
		queue_load(0, 16'h7fff);
		queue_load(TABLE_DEPTH - 1, 16'h8000);
		queue_load(11'h555, 16'h5555);
		queue_load(11'h2aa, 16'haaaa);
		queue_texel(32'h0, 1);
		queue_coord();
		queue_texel(32'hffffffff, 1);
		queue_unknown();
		queue_coord();
		queue_texel(32'h0, 0);
		wait_idle();

		// bilinear and blend at the smallest frame, through a frame end
		write_reg(REG_WIDTH, 2);
		write_reg(REG_HEIGHT, 2);
		write_reg(REG_BILINEAR, 1);
		write_reg(REG_BLEND, 1);
		for (int i = 0; i < 5; i++) begin
			queue_coord();
			queue_texel(32'hffffffff, i[0]);
		end

		for (int p = 0; p < 20; p++) begin
			// each phase holds off until every result is back
			wait_idle();
			if (p == 5) begin
				write_reg(REG_WIDTH, 2048);
				write_reg(REG_HEIGHT, 2048);
			end else if (p == 6) begin
				write_reg(REG_WIDTH, 4095);
				write_reg(REG_HEIGHT, 0);
			end else begin
				write_reg(REG_WIDTH, pick_size($urandom_range(0, 9)));
				write_reg(REG_HEIGHT, pick_size($urandom_range(0, 9)));
			end
			write_reg(REG_BILINEAR, $urandom_range(0, 1));
			write_reg(REG_BLEND, $urandom_range(0, 1));
			n = 0;
			while (n < 80) begin
				int r;
				r = $urandom_range(0, 99);
				if (r < 70) begin
					queue_coord();
					queue_texel('0, 0);
					n += 2;
				end else if (r < 80) begin
					queue_load($urandom_range(0, TABLE_DEPTH - 1), rand_scale());
					n++;
				end else if (r < 88) begin
					queue_coord();
					n++;
				end else if (r < 95) begin
					queue_texel('0, 0);
					n++;
				end else begin
					queue_unknown();
				end
			end
		end

		wait_idle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// cycle count and run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic bit noisy();
		return !(cycles >= 2000 && cycles < 5000) && ($urandom_range(0, 99) < 20);
	endfunction

	// input beat driver
	always @(posedge clk)
		in_took <= in_valid && !in_stall;

	always @(negedge clk) begin
		remap_beat_t b;
		if (arst_n && (!in_valid || in_took)) begin
			if (pending_beats.size() != 0 && !noisy()) begin
				b = pending_beats.pop_front();
				action <= b.act;
				table_index <= b.tidx;
				table_value <= b.tval;
				texel_00 <= b.t00;
				texel_01 <= b.t01;
				texel_10 <= b.t10;
				texel_11 <= b.t11;
				current_pixel <= b.cur;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side stall
	always @(negedge clk)
		out_stall <= arst_n ? noisy() : 1'b0;

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %h, got %h", name, exp_v, got_v);
			errors++;
		end
	endtask

	// result beat monitor
	always @(posedge clk) begin
		remap_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("kind", e.kind, kind);
				check_field("source_x", e.sx, source_x);
				check_field("source_y", e.sy, source_y);
				check_field("frac_x", e.fx, frac_x);
				check_field("frac_y", e.fy, frac_y);
				check_field("out_pixel", e.pix, out_pixel);
				check_field("row_end", e.rend, row_end);
				check_field("frame_end", e.fend, frame_end);
			end
		end
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/rdr_pkg.sv
hdl/rdr_ctrl.sv
hdl/rdr_datapath.sv
hdl/radial_distance_remap.sv
tb/radial_distance_remap_tb.sv
